// File: src/crre_pkg.sv
// ----------------------------------------------------------------------------
// crre_pkg: shared types and constants of the rectangle raster engine
// Command and result structs, function codes, register indexes.
// ----------------------------------------------------------------------------
package crre_pkg;

  localparam int DefScreenWidth  = 320;
  localparam int DefScreenHeight = 240;

  localparam logic [1:0] FUNC_RECT   = 2'd0;
  localparam logic [1:0] FUNC_PLOT   = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;
  localparam logic [1:0] FUNC_SPRITE = 2'd3;

  localparam logic [1:0] REG_AND_MASK = 2'd0;
  localparam logic [1:0] REG_XOR      = 2'd1;
  localparam logic [1:0] REG_SPRITES  = 2'd2;

  localparam logic [7:0] SPRITE_KEEP = 8'hF0;
  localparam logic [7:0] LOW_NIBBLE  = 8'h0F;
  localparam logic [7:0] XOR_RESET   = 8'd7;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] x_first;
    logic signed [15:0] y_first;
    logic signed [15:0] x_second;
    logic signed [15:0] y_second;
    logic               solid;
    logic               set_zero;
  } cmd_t;

  typedef struct packed {
    logic       status;
    logic [7:0] read_value;
  } res_t;

endpackage

// File: src/clipped_rectangle_raster_engine.sv
// ----------------------------------------------------------------------------
// clipped_rectangle_raster_engine: rectangle / plot / read engine
// Byte-per-pixel frame store with AND/XOR raster op, one command at a time.
// ----------------------------------------------------------------------------
// After reset the engine clears the frame store, one pixel per cycle
// (SCREEN_WIDTH*SCREEN_HEIGHT pixels, 76800 at defaults), with busy high.
// A command is taken when start is high and busy is low; busy then stays high
// until the result strobe. The result is on the result port for one cycle
// with done high and cannot be held off. A read passes setup, a wait state
// and a data state before the strobe. Each pixel write is a read-modify-write
// through the single frame store port in three steps per pixel (read, write,
// advance). Configuration writes may come any time the engine is idle.
module clipped_rectangle_raster_engine
  import crre_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DefScreenWidth,
  parameter int SCREEN_HEIGHT = DefScreenHeight
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  cmd_t       cmd,
  output logic       done,
  output res_t       result,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  localparam int Depth = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam logic signed [16:0] WMax = 17'(SCREEN_WIDTH - 1);
  localparam logic signed [16:0] HMax = 17'(SCREEN_HEIGHT - 1);
  localparam logic [AW-1:0] AddrLast = AW'(Depth - 1);
  localparam logic [AW-1:0] Stride   = AW'(SCREEN_WIDTH);

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_SETUP = 4'd2,
                         S_SPAN = 4'd3, S_RD = 4'd4, S_WR = 4'd5,
                         S_NEXT = 4'd6, S_RWAIT = 4'd7, S_RDATA = 4'd8,
                         S_DONE = 4'd9;

  // span phase codes for outlines
  localparam logic [2:0] P_FILL = 3'd0, P_TOP = 3'd1, P_BOT = 3'd2,
                         P_LEFT = 3'd3, P_RIGHT = 3'd4, P_END = 3'd5;

  logic [3:0]  state;
  logic [7:0]  and_mask, xor_col;
  logic        sprites;
  cmd_t        c;
  logic [7:0]  m, col;
  logic signed [16:0] x1, x2, y1, y2, lx, hx, ly, hy;
  logic signed [16:0] cx, cy;   // current pixel
  logic signed [16:0] ex, ey;   // span end
  logic [2:0]  phase;
  logic [AW-1:0] addr, clr;
  logic        we;
  logic [7:0]  wdata, rdata;
  res_t        res;

  crre_ram #(.Width(8), .Depth(Depth)) u_fs (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

  // pixel address: one multiply by the screen stride
  logic [AW-1:0] paddr;
  assign paddr = AW'(cx[15:0]) + AW'(cy[15:0]) * Stride;

  logic inb;
  assign inb = (c.x_first >= 0) && (c.y_first >= 0) &&
               (17'(c.x_first) <= WMax) && (17'(c.y_first) <= HMax);

  always_comb begin
    we = 1'b0;
    addr = paddr;
    wdata = (rdata & m) ^ col;
    if (state == S_CLEAR) begin
      we = 1'b1; addr = clr; wdata = 8'd0;
    end else if (state == S_WR) begin
      we = 1'b1;
    end
  end

  // next span of an outline, given the phase just finished
  logic [2:0] nphase;
  logic signed [16:0] nly, nhy;
  always_comb begin
    nphase = P_END;
    nly = ly; nhy = hy;
    case (phase)
      P_TOP: begin nly = ly + 17'sd1; nphase = P_BOT; end
      P_BOT: begin nhy = hy - 17'sd1; nphase = P_LEFT; end
      P_LEFT: nphase = P_RIGHT;
      default: nphase = P_END;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  assign result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      and_mask <= 8'd0;
      xor_col <= XOR_RESET;
      sprites <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_AND_MASK: and_mask <= cfg_data;
          REG_XOR:      xor_col  <= cfg_data;
          REG_SPRITES:  sprites  <= cfg_data[0];
          default: ;
        endcase
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AddrLast) state <= S_IDLE;
        end
        S_IDLE: if (start) begin
          c <= cmd;
          res <= '0;
          cx <= 17'(cmd.x_first);
          cy <= 17'(cmd.y_first);
          state <= S_SETUP;
        end
        S_SETUP: begin
          m <= ((c.func == FUNC_RECT && c.set_zero) ? 8'd0 : and_mask) |
               (sprites ? SPRITE_KEEP : 8'd0);
          col <= (c.func == FUNC_RECT && c.set_zero) ? 8'd0 : xor_col;
          case (c.func)
            FUNC_RECT: begin
              x1 <= (c.x_first > c.x_second) ? 17'(c.x_second) : 17'(c.x_first);
              x2 <= (c.x_first > c.x_second) ? 17'(c.x_first) : 17'(c.x_second);
              y1 <= (c.y_first > c.y_second) ? 17'(c.y_second) : 17'(c.y_first);
              y2 <= (c.y_first > c.y_second) ? 17'(c.y_first) : 17'(c.y_second);
              phase <= c.solid ? P_FILL : P_TOP;
              state <= S_SPAN;
              cx <= 17'sh10000;  // marks first entry into span setup
            end
            FUNC_PLOT: state <= inb ? S_RD : S_DONE;
            default: begin
              if (inb) state <= S_RWAIT;
              else begin res.status <= 1'b1; state <= S_DONE; end
            end
          endcase
        end
        S_SPAN: begin
          // first pass computes the clip box, later passes pick a span
          if (cx == 17'sh10000) begin
            lx <= (x1 < 0) ? 17'sd0 : x1;
            hx <= (x2 > WMax) ? WMax : x2;
            ly <= (y1 < 0) ? 17'sd0 : y1;
            hy <= (y2 > HMax) ? HMax : y2;
            cx <= 17'sd0;
          end else if (hx < lx || hy < ly) begin
            if (phase == P_FILL || phase == P_TOP) state <= S_DONE;
            else if (phase == P_END) state <= S_DONE;
            else if (phase == P_LEFT || phase == P_RIGHT) state <= S_DONE;
            else phase <= P_LEFT;
          end else begin
            case (phase)
              P_FILL: begin
                cx <= lx; cy <= ly; ex <= hx; ey <= hy; state <= S_RD;
              end
              P_TOP: begin
                if (ly == y1) begin
                  cx <= lx; cy <= ly; ex <= hx; ey <= ly; state <= S_RD;
                end else phase <= P_BOT;
              end
              P_BOT: begin
                if (hy == y2 && hy != y1) begin
                  cx <= lx; cy <= hy; ex <= hx; ey <= hy; state <= S_RD;
                end else phase <= P_LEFT;
              end
              P_LEFT: begin
                if (lx == x1) begin
                  cx <= lx; cy <= ly; ex <= lx; ey <= hy; state <= S_RD;
                end else phase <= P_RIGHT;
              end
              P_RIGHT: begin
                if (hx == x2 && hx != x1) begin
                  cx <= hx; cy <= ly; ex <= hx; ey <= hy; state <= S_RD;
                end else phase <= P_END;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_RD: state <= S_WR;        // read data registered this cycle
        S_WR: state <= S_NEXT;
        S_NEXT: begin
          if (c.func != FUNC_RECT) state <= S_DONE;
          else if (cx != ex) begin cx <= cx + 17'sd1; state <= S_RD; end
          else if (cy != ey) begin cx <= (phase == P_RIGHT) ? hx : lx;
            cy <= cy + 17'sd1; state <= S_RD; end
          else if (phase == P_FILL) state <= S_DONE;
          else begin
            phase <= nphase;
            ly <= nly;
            hy <= nhy;
            state <= S_SPAN;
          end
        end
        S_RWAIT: state <= S_RDATA;
        S_RDATA: begin
          if (c.func == FUNC_READ)
            res.read_value <= sprites ? (rdata & LOW_NIBBLE) : rdata;
          else
            res.read_value <= sprites ? {4'd0, rdata[7:4]} : 8'd0;
          state <= S_DONE;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: src/crre_ram.sv
// ----------------------------------------------------------------------------
// crre_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module crre_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: src/crre_checker.sv
// ----------------------------------------------------------------------------
// crre_checker: port-level checks of the raster engine
// Handshake and result rules seen at the top-level ports.
// ----------------------------------------------------------------------------
module crre_checker
  import crre_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input res_t result
);
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done without busy");
  a_one_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");
  a_take: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("command not taken");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status) |-> result.read_value == 8'd0)
    else $error("off-screen read with data");
endmodule

bind clipped_rectangle_raster_engine crre_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .result(result));
